### src/raw_image_header_and_mono12_unpacker_assert.svh
// assertion macros shared by the rim12 modules
`ifndef RAW_IMAGE_HEADER_AND_MONO12_UNPACKER_ASSERT_SVH
`define RAW_IMAGE_HEADER_AND_MONO12_UNPACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RIM12_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rim12 check failed");

// next-cycle implication, checked out of reset
`define RIM12_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rim12 check failed");

`endif

### src/rim12_pkg.sv
`default_nettype none
package rim12_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [7:0] FMT_MONO8   = 8'd0;
	localparam logic [7:0] FMT_MONO12P = 8'd1;

	// one or two results caused by a single byte; shared fields stored once
	typedef struct packed {
		logic        two;
		logic [1:0]  kind0;
		logic [1:0]  kind1;
		logic [11:0] pix0;
		logic [11:0] pix1;
		logic [14:0] row;
		logic [14:0] col0;
		logic [14:0] col1;
		logic [14:0] width;
		logic [14:0] height;
		logic [7:0]  fmt;
		logic [7:0]  bits;
	} job_t;

endpackage
`default_nettype wire

### src/rim12_byte_if.sv
`default_nettype none
interface rim12_byte_if;
	logic       valid;
	logic       ready;
	logic       file_start;
	logic [7:0] data_byte;

	modport source (output valid, output file_start, output data_byte, input ready);
	modport sink (input valid, input file_start, input data_byte, output ready);
endinterface
`default_nettype wire

### src/rim12_result_if.sv
`default_nettype none
interface rim12_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] pixel_value;
	logic [14:0] row_index;
	logic [14:0] column_index;
	logic [14:0] image_width;
	logic [14:0] image_height;
	logic [7:0]  pixel_format;
	logic [7:0]  bits_per_pixel;
	logic        last_of_item;

	modport source (output valid, output kind, output pixel_value, output row_index,
		output column_index, output image_width, output image_height,
		output pixel_format, output bits_per_pixel, output last_of_item, input ready);
	modport sink (input valid, input kind, input pixel_value, input row_index,
		input column_index, input image_width, input image_height,
		input pixel_format, input bits_per_pixel, input last_of_item, output ready);
endinterface
`default_nettype wire

### src/rim12_front.sv
`default_nettype none
`include "raw_image_header_and_mono12_unpacker_assert.svh"
module rim12_front (
	input  wire                 clk,
	input  wire                 arst_n,
	rim12_byte_if.sink          bytes,
	input  wire                 q_ready,
	output logic                push,
	output rim12_pkg::job_t     job
);

	localparam logic [1:0] MODE_HEADER = 2'd0;
	localparam logic [1:0] MODE_DATA   = 2'd1;
	localparam logic [1:0] MODE_IDLE   = 2'd2;

	localparam logic [5:0] OFF_FIRST    = 6'd0;
	localparam logic [5:0] OFF_SECOND   = 6'd1;
	localparam logic [5:0] OFF_S_WID_LO = 6'd2;
	localparam logic [5:0] OFF_S_WID_HI = 6'd3;
	localparam logic [5:0] OFF_S_BITS   = 6'd4;
	localparam logic [5:0] OFF_S_FMT    = 6'd6;
	localparam logic [5:0] OFF_S_LAST   = 6'd8;
	localparam logic [5:0] OFF_L_TOP_LO = 6'd12;
	localparam logic [5:0] OFF_L_TOP_HI = 6'd13;
	localparam logic [5:0] OFF_L_BOT_LO = 6'd20;
	localparam logic [5:0] OFF_L_BOT_HI = 6'd21;
	localparam logic [5:0] OFF_L_WID_LO = 6'd24;
	localparam logic [5:0] OFF_L_WID_HI = 6'd25;
	localparam logic [5:0] OFF_L_BITS   = 6'd28;
	localparam logic [5:0] OFF_L_FMT    = 6'd32;
	localparam logic [5:0] OFF_L_LAST   = 6'd35;

	logic [1:0]  mode_q;
	logic [5:0]  off_q;
	logic        long_q;
	logic [7:0]  first_q;
	logic [15:0] width_q, toph_q, bot_q;
	logic [7:0]  fmt_q, bits_q;
	logic [1:0]  phase_q;
	logic [15:0] hold_q;
	logic [14:0] row_q, col_q;

	logic [1:0]  cur_mode, n_mode;
	logic [5:0]  cur_off, n_off;
	logic        cur_long, n_long;
	logic [7:0]  cur_first, n_first;
	logic [15:0] cur_width, n_width, cur_toph, n_toph, cur_bot, n_bot;
	logic [7:0]  cur_fmt, n_fmt, cur_bits, n_bits;
	logic [1:0]  cur_phase, n_phase;
	logic [15:0] cur_hold, n_hold;
	logic [14:0] cur_row, n_row, cur_col, n_col;
	logic [14:0] wid, hgt;
	logic [15:0] h16, c16, r16;
	logic [5:0]  last_off;
	logic        do_adv, has_res;
	logic [1:0]  step;
	logic        accept;
	logic [7:0]  b;

	assign bytes.ready = q_ready;
	assign accept = bytes.valid && q_ready;
	assign b = bytes.data_byte;

	always_comb begin
		// a file start restarts parsing with this byte as byte 0
		if (bytes.file_start) begin
			cur_mode = MODE_HEADER;
			cur_off = '0;
			cur_long = 1'b0;
			cur_first = '0;
			cur_width = '0;
			cur_toph = '0;
			cur_bot = '0;
			cur_fmt = '0;
			cur_bits = '0;
			cur_phase = '0;
			cur_hold = '0;
			cur_row = '0;
			cur_col = '0;
		end else begin
			cur_mode = mode_q;
			cur_off = off_q;
			cur_long = long_q;
			cur_first = first_q;
			cur_width = width_q;
			cur_toph = toph_q;
			cur_bot = bot_q;
			cur_fmt = fmt_q;
			cur_bits = bits_q;
			cur_phase = phase_q;
			cur_hold = hold_q;
			cur_row = row_q;
			cur_col = col_q;
		end

		wid = cur_width[15] ? 15'd0 : cur_width[14:0];
		h16 = cur_long ? (cur_bot - cur_toph) : cur_toph;
		hgt = h16[15] ? 15'd0 : h16[14:0];
		last_off = (cur_off >= 6'd2 && cur_long) ? OFF_L_LAST : OFF_S_LAST;

		n_mode = cur_mode;
		n_off = cur_off;
		n_long = cur_long;
		n_first = cur_first;
		n_width = cur_width;
		n_toph = cur_toph;
		n_bot = cur_bot;
		n_fmt = cur_fmt;
		n_bits = cur_bits;
		n_phase = cur_phase;
		n_hold = cur_hold;
		n_row = cur_row;
		n_col = cur_col;
		do_adv = 1'b0;
		step = 2'd1;
		has_res = 1'b0;
		c16 = '0;
		r16 = '0;

		job.two = 1'b0;
		job.kind0 = rim12_pkg::KIND_PIXEL;
		job.kind1 = rim12_pkg::KIND_PIXEL;
		job.pix0 = '0;
		job.pix1 = '0;
		job.row = cur_row;
		job.col0 = cur_col;
		job.col1 = cur_col + 15'd1;
		job.width = wid;
		job.height = hgt;
		job.fmt = cur_fmt;
		job.bits = cur_bits;

		case (cur_mode)
			MODE_HEADER: begin
				if (cur_off == OFF_FIRST) begin
					n_first = b;
				end else if (cur_off == OFF_SECOND) begin
					n_long = (cur_first == 8'd0) && (b == 8'd0);
					if (!n_long) n_toph = {b, cur_first};
				end else if (cur_long) begin
					case (cur_off)
						OFF_L_TOP_LO: n_toph[7:0] = b;
						OFF_L_TOP_HI: n_toph[15:8] = b;
						OFF_L_BOT_LO: n_bot[7:0] = b;
						OFF_L_BOT_HI: n_bot[15:8] = b;
						OFF_L_WID_LO: n_width[7:0] = b;
						OFF_L_WID_HI: n_width[15:8] = b;
						OFF_L_BITS:   n_bits = b;
						OFF_L_FMT:    n_fmt = b;
						default: ;
					endcase
				end else begin
					case (cur_off)
						OFF_S_WID_LO: n_width[7:0] = b;
						OFF_S_WID_HI: n_width[15:8] = b;
						OFF_S_BITS:   n_bits = b;
						OFF_S_FMT:    n_fmt = b;
						default: ;
					endcase
				end

				if (cur_off != last_off) begin
					n_off = cur_off + 6'd1;
				end else begin
					// last header byte: no field lands here, so current values stand
					has_res = 1'b1;
					job.kind0 = rim12_pkg::KIND_HEADER;
					job.kind1 = rim12_pkg::KIND_ERROR;
					job.row = '0;
					job.col0 = '0;
					job.col1 = '0;
					if (cur_fmt > rim12_pkg::FMT_MONO12P) begin
						job.two = 1'b1;
						n_mode = MODE_IDLE;
					end else if (wid == 15'd0 || hgt == 15'd0) begin
						n_mode = MODE_IDLE;
					end else begin
						n_mode = MODE_DATA;
						n_phase = '0;
						n_hold = '0;
						n_row = '0;
						n_col = '0;
					end
				end
			end
			MODE_DATA: begin
				if (cur_fmt == rim12_pkg::FMT_MONO8) begin
					has_res = 1'b1;
					job.pix0 = {4'd0, b};
					do_adv = 1'b1;
				end else begin
					case (cur_phase)
						2'd0: begin
							n_hold[7:0] = b;
							n_phase = 2'd1;
						end
						2'd1: begin
							n_hold[15:8] = b;
							n_phase = 2'd2;
						end
						default: begin
							has_res = 1'b1;
							job.pix0 = {cur_hold[7:0], cur_hold[15:12]};
							job.pix1 = {b, cur_hold[11:8]};
							job.two = ({1'b0, cur_col} + 16'd1) < {1'b0, wid};
							n_phase = 2'd0;
							step = 2'd2;
							do_adv = 1'b1;
						end
					endcase
				end
				if (do_adv) begin
					c16 = {1'b0, cur_col} + {14'd0, step};
					r16 = {1'b0, cur_row} + 16'd1;
					if (c16 >= {1'b0, wid}) begin
						n_col = '0;
						n_row = r16[14:0];
						if (r16 >= {1'b0, hgt}) n_mode = MODE_IDLE;
					end else begin
						n_col = c16[14:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign push = accept && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			off_q <= '0;
			long_q <= 1'b0;
			first_q <= '0;
			width_q <= '0;
			toph_q <= '0;
			bot_q <= '0;
			fmt_q <= '0;
			bits_q <= '0;
			phase_q <= '0;
			hold_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			mode_q <= n_mode;
			off_q <= n_off;
			long_q <= n_long;
			first_q <= n_first;
			width_q <= n_width;
			toph_q <= n_toph;
			bot_q <= n_bot;
			fmt_q <= n_fmt;
			bits_q <= n_bits;
			phase_q <= n_phase;
			hold_q <= n_hold;
			row_q <= n_row;
			col_q <= n_col;
		end
	end

	`RIM12_ASSERT_IMPLY(a_data_fmt_known, mode_q == MODE_DATA, fmt_q <= rim12_pkg::FMT_MONO12P)

endmodule
`default_nettype wire

### src/rim12_fifo.sv
`default_nettype none
`include "raw_image_header_and_mono12_unpacker_assert.svh"
module rim12_fifo #(
	parameter int QDEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire rim12_pkg::job_t wdata,
	output logic                not_full,
	input  wire                 pop,
	output logic                not_empty,
	output rim12_pkg::job_t     head
);

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	rim12_pkg::job_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign not_full = cnt_q != CW'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`RIM12_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q <= CW'(QDEPTH))
	`RIM12_ASSERT_IMPLY(a_no_pop_empty, pop, cnt_q != '0)

endmodule
`default_nettype wire

### src/rim12_back.sv
`default_nettype none
`include "raw_image_header_and_mono12_unpacker_assert.svh"
module rim12_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  wire rim12_pkg::job_t head,
	output logic                pop,
	rim12_result_if.source      results
);

	logic sel_q;
	logic last;

	// second result of a pair goes out on the following request
	assign last = sel_q || !head.two;
	assign pop = results.valid && results.ready && last;

	assign results.valid = head_valid;
	assign results.kind = sel_q ? head.kind1 : head.kind0;
	assign results.pixel_value = sel_q ? head.pix1 : head.pix0;
	assign results.row_index = head.row;
	assign results.column_index = sel_q ? head.col1 : head.col0;
	assign results.image_width = head.width;
	assign results.image_height = head.height;
	assign results.pixel_format = head.fmt;
	assign results.bits_per_pixel = head.bits;
	assign results.last_of_item = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (results.valid && results.ready) begin
			sel_q <= !last;
		end
	end

	`RIM12_ASSERT_IMPLY(a_sel_pair, sel_q, head_valid && head.two)
	`RIM12_ASSERT_NEXT(a_pair_follows, results.valid && results.ready && !last,
		results.valid && sel_q)

endmodule
`default_nettype wire

### src/raw_image_header_and_mono12_unpacker.sv
// channel   dir  handshake      payload
// bytes     in   valid/ready    file_start, data_byte
// results   out  valid/ready    kind, pixel_value, row_index, column_index,
//                               image_width, image_height, pixel_format,
//                               bits_per_pixel, last_of_item
//
// one byte accepted per cycle while the result queue has room
// a byte with two results (12 bit pixel pair, header plus error) drains as two separate results
// the single result port carries one result per cycle while results are ready
// arst_n clears parse state, queue and output select; header parsing starts at byte 0
// results stall independently of bytes through the queue of QDEPTH entries
`default_nettype none
module raw_image_header_and_mono12_unpacker #(
	parameter int QDEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	rim12_byte_if.sink      bytes,
	rim12_result_if.source  results
);

	rim12_pkg::job_t job, head;
	logic push, q_ready, pop, head_valid;

	rim12_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.q_ready (q_ready),
		.push    (push),
		.job     (job)
	);

	rim12_fifo #(
		.QDEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (job),
		.not_full  (q_ready),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head)
	);

	rim12_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule
`default_nettype wire
